/* rtl/plit_pkg.sv */
// shared types and constants for the piecewise linear interpolation table
package plit_pkg;

    localparam int MAX_POINTS = 16;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DATA_W     = 32;
    localparam int ENTRY_W    = 2 * DATA_W;
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_FEW   = 3'd3,
        ST_BELOW = 3'd4,
        ST_ABOVE = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_QUERY  = 1'b1
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PLACE,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_Q_RD,
        S_Q_CMP,
        S_DIFF,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FIN
    } state_t;

endpackage

/* rtl/plit_ram.sv */
// generic simple dual-port ram with registered read
module plit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/plit_div.sv */
// iterative restoring divider, 64 by 32 bits, quotient known to fit 32 bits
module plit_div import plit_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [ENTRY_W-1:0]  dividend,
    input  logic [DATA_W-1:0]   divisor,
    output logic                done,
    output logic [DATA_W-1:0]   quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dsr_reg, dsr_next;
    logic [DATA_W:0]      trial;

    // upper half is below the divisor, so the partial remainder stays in 32 bits
    assign trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[ENTRY_W-1:DATA_W];
            quo_next  = dividend[DATA_W-1:0];
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (!trial[DATA_W]) begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/piecewise_linear_interp_table.sv */
// top level: sorted breakpoint table with insert and interpolating lookup
//
// Each item is either an insert (func 0) or a query (func 1) and yields exactly one
// result item. Breakpoints (x, value) live in one 64-bit wide RAM of MAX_POINTS
// entries with a registered read; the single read port sets the pace. An insert
// scans the table until it finds its place or a duplicate, then, unless the table
// is full, shifts the upper entries up one by one and writes the new point. Scan
// and shift together read no stored entry more than once, but for the one at the
// slot, which they read twice. A query scans segments from the bottom, then forms
// the differences and the product and starts and runs the bit-serial divider; an
// error answer skips the divide. Items are taken one at a time; the result sits in
// an output register, so the next item is accepted while it waits.
// After reset the table is empty and needs no clearing pass.
module piecewise_linear_interp_table import plit_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [0:0]         s_func,
    input  logic signed [31:0] s_x_in,
    input  logic signed [31:0] s_val_in,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value_out,
    output logic [2:0]         m_status
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [ADDR_W-1:0]   j_reg, j_next;
    logic signed [31:0]  x_reg, x_next;
    logic [31:0]         val_reg, val_next;
    logic signed [31:0]  x0_reg, x0_next;
    logic [31:0]         v0_reg, v0_next;
    logic signed [31:0]  x1_reg, x1_next;
    logic [31:0]         v1_reg, v1_next;
    logic [31:0]         dx_reg, dx_next;
    logic [31:0]         span_reg, span_next;
    logic [31:0]         mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [ENTRY_W-1:0]  prod_reg, prod_next;
    logic [31:0]         res_val_reg, res_val_next;
    status_t             res_st_reg, res_st_next;
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         m_value_reg, m_value_next;
    status_t             m_status_reg, m_status_next;

    // memory port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic signed [31:0]  rd_x;
    logic [31:0]         rd_v;

    // divider
    logic                div_start;
    logic                div_done;
    logic [31:0]         div_q;

    // segment arithmetic
    logic [32:0]         dv_wide;
    logic [32:0]         dv_abs;
    logic [31:0]         span_raw;

    assign rd_x = $signed(ram_rdata[ENTRY_W-1:DATA_W]);
    assign rd_v = ram_rdata[DATA_W-1:0];

    assign dv_wide  = {v1_reg[31], v1_reg} - {v0_reg[31], v0_reg};
    assign dv_abs   = dv_wide[32] ? (33'd0 - dv_wide) : dv_wide;
    assign span_raw = x1_reg - x0_reg;

    plit_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    plit_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        j_next       = j_reg;
        x_next       = x_reg;
        val_next     = val_reg;
        x0_next      = x0_reg;
        v0_next      = v0_reg;
        x1_next      = x1_reg;
        v1_next      = v1_reg;
        dx_next      = dx_reg;
        span_next    = span_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        prod_next    = prod_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_status_next = m_status_reg;

        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = {x_reg, val_reg};
        ram_raddr = idx_reg[ADDR_W-1:0];
        div_start = 1'b0;

        // result register empties independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    x_next       = s_x_in;
                    val_next     = s_val_in;
                    idx_next     = '0;
                    res_val_next = '0;
                    if (s_func == FUNC_INSERT) begin
                        state_next = S_INS_RD;
                    end else if (count_reg < CNT_W'(2)) begin
                        res_st_next = ST_FEW;
                        state_next  = S_FIN;
                    end else begin
                        state_next = S_Q_RD;
                    end
                end
            end

            // insert: find the slot, stop on a duplicate
            S_INS_RD: begin
                if (idx_reg == count_reg) begin
                    pos_next   = idx_reg[ADDR_W-1:0];
                    state_next = S_INS_PLACE;
                end else begin
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                if (x_reg == rd_x) begin
                    res_st_next = ST_DUP;
                    state_next  = S_FIN;
                end else if (x_reg < rd_x) begin
                    pos_next   = idx_reg[ADDR_W-1:0];
                    state_next = S_INS_PLACE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_INS_RD;
                end
            end

            S_INS_PLACE: begin
                if (count_reg >= CNT_W'(MAX_POINTS)) begin
                    res_st_next = ST_FULL;
                    state_next  = S_FIN;
                end else if (count_reg[ADDR_W-1:0] > pos_reg) begin
                    j_next     = count_reg[ADDR_W-1:0];
                    state_next = S_SH_RD;
                end else begin
                    state_next = S_INS_WR;
                end
            end

            // move entry j-1 up to j, top down
            S_SH_RD: begin
                ram_raddr  = j_reg - 1'b1;
                state_next = S_SH_WR;
            end

            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = ram_rdata;
                j_next    = j_reg - 1'b1;
                if ((j_reg - 1'b1) == pos_reg) begin
                    state_next = S_INS_WR;
                end else begin
                    state_next = S_SH_RD;
                end
            end

            S_INS_WR: begin
                ram_we      = 1'b1;
                ram_waddr   = pos_reg;
                ram_wdata   = {x_reg, val_reg};
                count_next  = count_reg + 1'b1;
                res_st_next = ST_OK;
                state_next  = S_FIN;
            end

            // query: walk segments from the bottom
            S_Q_RD: begin
                state_next = S_Q_CMP;
            end

            S_Q_CMP: begin
                if (idx_reg == '0) begin
                    if (x_reg < rd_x) begin
                        res_st_next = ST_BELOW;
                        state_next  = S_FIN;
                    end else begin
                        x0_next    = rd_x;
                        v0_next    = rd_v;
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_Q_RD;
                    end
                end else if (x_reg <= rd_x) begin
                    x1_next    = rd_x;
                    v1_next    = rd_v;
                    state_next = S_DIFF;
                end else begin
                    x0_next = rd_x;
                    v0_next = rd_v;
                    if (CNT_W'(idx_reg + 1'b1) == count_reg) begin
                        res_st_next = ST_ABOVE;
                        state_next  = S_FIN;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_Q_RD;
                    end
                end
            end

            S_DIFF: begin
                dx_next    = x_reg - x0_reg;
                span_next  = (span_raw == '0) ? 32'd1 : span_raw;
                mag_next   = dv_abs[31:0];
                neg_next   = dv_wide[32];
                state_next = S_MUL;
            end

            S_MUL: begin
                prod_next  = ENTRY_W'(mag_reg) * ENTRY_W'(dx_reg);
                state_next = S_DIV_GO;
            end

            S_DIV_GO: begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT: begin
                if (div_done) begin
                    res_val_next = neg_reg ? (v0_reg - div_q) : (v0_reg + div_q);
                    res_st_next  = ST_OK;
                    state_next   = S_FIN;
                end
            end

            // hand the answer to the output register once it is free
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_val_reg;
                    m_status_next = res_st_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        j_reg        <= j_next;
        x_reg        <= x_next;
        val_reg      <= val_next;
        x0_reg       <= x0_next;
        v0_reg       <= v0_next;
        x1_reg       <= x1_next;
        v1_reg       <= v1_next;
        dx_reg       <= dx_next;
        span_reg     <= span_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        res_val_reg  <= res_val_next;
        res_st_reg   <= res_st_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_value_out = $signed(m_value_reg);
    assign m_status    = m_status_reg;

endmodule

/* rtl/plit_checker.sv */
// port-level checks for the interpolation table, bound to the top level
module plit_checker import plit_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [0:0]         s_func,
    input logic signed [31:0] s_x_in,
    input logic signed [31:0] s_val_in,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_value_out,
    input logic [2:0]         m_status
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a waiting input item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_func) && $stable(s_x_in)
            && $stable(s_val_in))
        else $error("waiting input item changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_out) && $stable(m_status))
        else $error("stalled result changed");

    // any answer other than ok carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> m_value_out == 32'sd0)
        else $error("error result with nonzero value");

    // one item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted back to back");

endmodule

bind piecewise_linear_interp_table plit_checker u_plit_checker (.*);

/* verif/testbench.sv */
// self-checking testbench for the piecewise linear interpolation table
module testbench import plit_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // clocking, reset and run length
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 11;
    localparam int TIMEOUT_CYCLES = 800_000;
    // worst item is a long insert shift or a last-segment query
    localparam int DRAIN_CYCLES   = 200;

    // random part shaping
    localparam int RANDOM_ITEMS   = 1750;
    localparam int IDLE_PCT       = 27;
    localparam int STEADY_FIRST   = 300;     // sender offers back to back in this span
    localparam int STEADY_LAST    = 700;
    localparam int HOLD_AT_ITEM   = 200;     // receiver stops taking results here
    localparam int HOLD_CYCLES    = 600;
    localparam int PAUSE_AT_ITEM  = 1000;    // sender waits for the block to drain here
    localparam int RX_STEADY_FROM = 20_000;  // receiver never stalls in this cycle window
    localparam int RX_STEADY_TO   = 40_000;

    localparam longint X_MIN     = -(longint'(1) << 31);
    localparam longint X_MAX     = (longint'(1) << 31) - 1;
    localparam longint NEAR_SPAN = 'h90000;  // about +/- 9.0 in Q16.16

    // one answer of the block
    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
    } answer_t;

    // one row of the directed table; when known is clear the shadow table decides
    typedef struct packed {
        func_t             op;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] val;
        logic              known;
        logic [DATA_W-1:0] exp_value;
        status_t           exp_status;
    } directed_row_t;

    localparam int N_DIRECTED = 23;
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // empty table, then a single point: too few points either way
        '{FUNC_QUERY,  32'h0000_0000, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_FEW},
        '{FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{FUNC_QUERY,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_FEW},
        // same x again is refused
        '{FUNC_INSERT, 32'h0000_0000, 32'h0000_0005, 1'b1, 32'h0000_0000, ST_DUP},
        '{FUNC_INSERT, 32'h0001_0000, 32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_OK},
        // extremes of x fall outside the domain [0, 1.0]
        '{FUNC_QUERY,  32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_BELOW},
        '{FUNC_QUERY,  32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_ABOVE},
        '{FUNC_QUERY,  32'hffff_ffff, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_BELOW},
        '{FUNC_QUERY,  32'h0001_0001, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_ABOVE},
        // both ends of the only segment
        '{FUNC_QUERY,  32'h0001_0000, 32'ha5a5_a5a5, 1'b1, 32'h7fff_ffff, ST_OK},
        '{FUNC_QUERY,  32'h0000_0000, 32'h5a5a_5a5a, 1'b1, 32'h0000_0000, ST_OK},
        '{FUNC_QUERY,  32'h0000_8000, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        // insert at the front (full shift) and at the back, extreme values
        '{FUNC_INSERT, 32'hffff_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{FUNC_INSERT, 32'h0002_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
        // a shared inner breakpoint answers with its own value
        '{FUNC_QUERY,  32'h0001_0000, 32'h1234_5678, 1'b1, 32'h7fff_ffff, ST_OK},
        '{FUNC_QUERY,  32'h0000_0000, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK},
        // steepest falling and rising segments
        '{FUNC_QUERY,  32'h0001_8000, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FUNC_QUERY,  32'hffff_8000, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        // insert in the middle, then read around it
        '{FUNC_INSERT, 32'h0000_8000, 32'h1234_5678, 1'b1, 32'h0000_0000, ST_OK},
        '{FUNC_QUERY,  32'h0000_4000, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FUNC_QUERY,  32'h0001_ffff, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FUNC_INSERT, 32'h0002_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_DUP},
        '{FUNC_QUERY,  32'hffff_0000, 32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK}
    };

    // block ports, the inputs known from time zero
    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    logic [0:0]               s_func      = FUNC_INSERT;
    logic signed [DATA_W-1:0] s_x_in      = '0;
    logic signed [DATA_W-1:0] s_val_in    = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    logic signed [DATA_W-1:0] m_value_out;
    logic [2:0]               m_status;

    // shadow copy of the breakpoint table
    logic signed [DATA_W-1:0] shadow_x   [MAX_POINTS];
    logic signed [DATA_W-1:0] shadow_val [MAX_POINTS];
    int                       shadow_count = 0;

    // answers owed by the block, oldest first
    answer_t expected_answers [$];
    int      mismatch_count = 0;

    // sender pacing flag and hold request to the receiver
    logic steady_send  = 1'b0;
    logic hold_request = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    piecewise_linear_interp_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_x_in      (s_x_in),
        .s_val_in    (s_val_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_out (m_value_out),
        .m_status    (m_status)
    );

    // apply one item to the shadow table and return the answer it earns
    function automatic answer_t interp_table_step(func_t op, logic signed [DATA_W-1:0] x,
                                                  logic signed [DATA_W-1:0] v);
        answer_t         ans;
        int              pos;
        int              seg;
        logic            hit;
        longint          x0, x1, v0, v1, dv, res;
        longint unsigned dx, span, mag, quo;
        ans.value  = '0;
        ans.status = ST_OK;
        if (op == FUNC_INSERT) begin
            // find the slot; an equal x stops the scan before the full test
            pos = shadow_count;
            hit = 1'b0;
            for (int i = 0; i < shadow_count && !hit; i++) begin
                if (x == shadow_x[i]) begin
                    ans.status = ST_DUP;
                    hit = 1'b1;
                end else if (x < shadow_x[i]) begin
                    pos = i;
                    hit = 1'b1;
                end
            end
            if (ans.status != ST_DUP) begin
                if (shadow_count >= MAX_POINTS) begin
                    ans.status = ST_FULL;
                end else begin
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_x[i]   = shadow_x[i - 1];
                        shadow_val[i] = shadow_val[i - 1];
                    end
                    shadow_x[pos]   = x;
                    shadow_val[pos] = v;
                    shadow_count++;
                end
            end
        end else if (shadow_count < 2) begin
            ans.status = ST_FEW;
        end else if (x < shadow_x[0]) begin
            ans.status = ST_BELOW;
        end else begin
            // first segment that holds x, so a shared point takes the lower one
            seg = -1;
            for (int i = 0; i + 1 < shadow_count && seg < 0; i++) begin
                if (x >= shadow_x[i] && x <= shadow_x[i + 1])
                    seg = i;
            end
            if (seg < 0) begin
                ans.status = ST_ABOVE;
            end else begin
                x0   = shadow_x[seg];
                x1   = shadow_x[seg + 1];
                v0   = shadow_val[seg];
                v1   = shadow_val[seg + 1];
                dx   = longint'(x) - x0;
                span = x1 - x0;
                dv   = v1 - v0;
                mag  = (dv < 0) ? -dv : dv;
                // magnitude times offset stays below 2^64, quotient truncates to zero
                quo  = (mag * dx) / span;
                res  = (dv < 0) ? v0 - longint'(quo) : v0 + longint'(quo);
                ans.value = res[DATA_W-1:0];
            end
        end
        return ans;
    endfunction

    // uniform pick in [lo, hi], spans up to the whole 32-bit range
    function automatic longint rand_span(longint lo, longint hi);
        longint unsigned width;
        width = hi - lo + 1;
        return lo + longint'({$urandom, $urandom} % width);
    endfunction

    // query x: mostly inside the domain, some on breakpoints, just outside, or anywhere
    function automatic logic signed [DATA_W-1:0] pick_query_x();
        int     mode;
        int     k;
        longint lo, hi, pick;
        mode = $urandom_range(99);
        pick = rand_span(X_MIN, X_MAX);
        if (shadow_count >= 2) begin
            lo = shadow_x[0];
            hi = shadow_x[shadow_count - 1];
            if (mode < 35) begin
                k    = $urandom_range(shadow_count - 2);
                pick = rand_span(shadow_x[k], shadow_x[k + 1]);
            end else if (mode < 50) begin
                pick = shadow_x[$urandom_range(shadow_count - 1)];
            end else if (mode < 60 && lo > X_MIN) begin
                pick = $urandom_range(1) ? lo - 1 : rand_span(X_MIN, lo - 1);
            end else if (mode < 70 && hi < X_MAX) begin
                pick = $urandom_range(1) ? hi + 1 : rand_span(hi + 1, X_MAX);
            end else if (mode < 85) begin
                pick = rand_span(-NEAR_SPAN, NEAR_SPAN);
            end
        end
        return pick[DATA_W-1:0];
    endfunction

    // insert x: some repeats of stored points, the rest spread wide or clustered
    function automatic logic signed [DATA_W-1:0] pick_insert_x();
        int     mode;
        longint pick;
        mode = $urandom_range(99);
        if (mode < 15 && shadow_count > 0)
            pick = shadow_x[$urandom_range(shadow_count - 1)];
        else if (mode < 55)
            pick = rand_span(X_MIN, X_MAX);
        else
            pick = rand_span(-NEAR_SPAN, NEAR_SPAN);
        return pick[DATA_W-1:0];
    endfunction

    // breakpoint value with extra weight on the extremes and zero
    function automatic logic signed [DATA_W-1:0] pick_value();
        int mode;
        mode = $urandom_range(99);
        if (mode < 5)
            return X_MIN[DATA_W-1:0];
        else if (mode < 10)
            return X_MAX[DATA_W-1:0];
        else if (mode < 15)
            return '0;
        return $urandom;
    endfunction

    // queue one owed answer behind the ones already waiting
    task automatic owe_answer(answer_t ans);
        expected_answers.insert(expected_answers.size(), ans);
    endtask

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        mismatch_count++;
        $display("mismatch on %s: got %h expected %h at %0t ns", what, got, want, $time);
    endtask

    task automatic check_answer(logic [DATA_W-1:0] got_value, logic [2:0] got_status);
        answer_t owed;
        if (expected_answers.size() == 0) begin
            report_mismatch("unowed result item", got_value, '0);
            return;
        end
        owed = expected_answers.pop_front();
        if (got_value !== owed.value)
            report_mismatch("value_out", got_value, owed.value);
        if (got_status !== owed.status)
            report_mismatch("status", DATA_W'(got_status), DATA_W'(owed.status));
    endtask

    // random idle cycles before the next item, none during the steady span
    task automatic sender_gap();
        while (!steady_send && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // present one item and hold it until the block takes it
    task automatic offer_item(func_t op, logic signed [DATA_W-1:0] x,
                              logic signed [DATA_W-1:0] v);
        s_valid  <= 1'b1;
        s_func   <= op;
        s_x_in   <= x;
        s_val_in <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender: reset, directed table, random items, drain, verdict
    initial begin : sender
        answer_t                  ans;
        directed_row_t            row;
        func_t                    op;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] v;
        int                       insert_pct;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part: typed answers where obvious, shadow table otherwise
        for (int r = 0; r < N_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            sender_gap();
            offer_item(row.op, row.x, row.val);
            ans = interp_table_step(row.op, row.x, row.val);
            if (row.known) begin
                ans.value  = row.exp_value;
                ans.status = row.exp_status;
            end
            owe_answer(ans);
        end

        // random part: inserts fill the table early, then mostly queries against it,
        // with a trickle of inserts that must come back as duplicate or full
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT_ITEM)
                hold_request = 1'b1;
            if (n == PAUSE_AT_ITEM) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (expected_answers.size() != 0);
            end
            steady_send = (n >= STEADY_FIRST && n < STEADY_LAST);
            insert_pct  = (shadow_count < MAX_POINTS) ? 25 : 6;
            if ($urandom_range(99) < insert_pct) begin
                op = FUNC_INSERT;
                x  = pick_insert_x();
            end else begin
                op = FUNC_QUERY;
                x  = pick_query_x();
            end
            // value goes out on queries too, where it must be ignored
            v = pick_value();
            sender_gap();
            offer_item(op, x, v);
            owe_answer(interp_table_step(op, x, v));
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_answers.size() != 0);
        // stray results after the last owed one still count against the block
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // receiver: checks on each accepted result, random stalls, one long hold-off
    initial begin : receiver
        int   hold_left;
        int   rx_cycle;
        logic hold_done;
        hold_left = 0;
        rx_cycle  = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (aresetn && m_valid && m_ready)
                check_answer(m_value_out, m_status);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_request && !hold_done) begin
                // block fills its output and then stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (rx_cycle >= RX_STEADY_FROM && rx_cycle < RX_STEADY_TO) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // hard stop well beyond the slowest passing run
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAIL");
        $finish;
    end

endmodule

/* piecewise_linear_interp_table.f */
rtl/plit_pkg.sv
rtl/plit_ram.sv
rtl/plit_div.sv
rtl/piecewise_linear_interp_table.sv
rtl/plit_checker.sv
verif/testbench.sv
